[sv/ebpl_pkg.sv]
package ebpl_pkg;

    localparam logic [7:0] SEP_MARK = 8'hFF;

    // Configuration register indexes
    localparam logic [1:0] REG_ESCAPE_VALUE = 2'd0;
    localparam logic [1:0] REG_PATCH_LIMIT  = 2'd1;
    localparam logic [1:0] REG_PATCH_START  = 2'd2;

    localparam logic [7:0] ESCAPE_VALUE_RST = 8'd254;
    localparam logic [7:0] PATCH_LIMIT_RST  = 8'd200;
    localparam logic [7:0] PATCH_START_RST  = 8'd0;

    // Result kinds
    localparam logic ITEM_PAYLOAD = 1'b0;
    localparam logic ITEM_PATCH   = 1'b1;

    // Pending result bits of a job, in output order
    localparam int PEND_BYTE  = 0;
    localparam int PEND_ESC   = 1;
    localparam int PEND_BLOCK = 2;
    localparam int PEND_FINAL = 3;
    localparam int PEND_W     = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified input item: its payload byte and up to three patch writes
    typedef struct packed {
        logic [PEND_W-1:0] pend;
        logic [7:0]        data;
        logic [7:0]        esc_slot;
        logic [7:0]        esc_val;
        logic [7:0]        block_slot;
        logic [7:0]        final_slot;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[sv/ebpl_front.sv]
module ebpl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  ebpl_pkg::queue_stat_t q_stat,
    output logic                 push,
    output ebpl_pkg::job_t       job
);
    import ebpl_pkg::*;

    logic [7:0] escape_value_reg;
    logic [7:0] patch_limit_reg;
    logic [7:0] patch_start_reg;

    logic [7:0] block_position_reg, block_position_next;
    logic [7:0] list_cursor_reg, list_cursor_next;
    logic       list_full_reg, list_full_next;
    logic       in_stream_reg, in_stream_next;

    logic [7:0] cur0, cur1, pos0, last_pos;
    logic [8:0] inc0, inc1;
    logic       full0, full1, esc, ovf0, ovf1, blk_end, blk_wr;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        // a new stream starts from patch_start with a fresh block
        cur0  = in_stream_reg ? list_cursor_reg : patch_start_reg;
        pos0  = in_stream_reg ? block_position_reg : 8'd0;
        full0 = in_stream_reg ? list_full_reg : 1'b0;

        esc  = !full0 && (s_tdata == escape_value_reg);
        inc0 = {1'b0, cur0} + 9'd1;
        ovf0 = inc0 >= {1'b0, patch_limit_reg};

        full1 = full0 || (esc && ovf0);
        cur1  = (esc && !ovf0) ? inc0[7:0] : cur0;

        last_pos = escape_value_reg - 8'd2;
        blk_end  = (pos0 == last_pos);
        blk_wr   = !full1 && blk_end;
        inc1     = {1'b0, cur1} + 9'd1;
        ovf1     = inc1 >= {1'b0, patch_limit_reg};

        list_full_next      = full1 || (blk_wr && ovf1);
        list_cursor_next    = (blk_wr && !ovf1) ? inc1[7:0] : cur1;
        block_position_next = full1 ? pos0 : (blk_end ? 8'd0 : pos0 + 8'd1);
        in_stream_next      = !s_tlast;

        job.pend[PEND_BYTE]  = 1'b1;
        job.pend[PEND_ESC]   = esc;
        job.pend[PEND_BLOCK] = blk_wr;
        job.pend[PEND_FINAL] = !full1 && s_tlast && !list_full_next
                               && (block_position_next != 8'd0);
        job.data       = esc ? SEP_MARK : s_tdata;
        job.esc_slot   = cur0;
        job.esc_val    = ovf0 ? SEP_MARK : pos0 + 8'd1;
        job.block_slot = cur1;
        job.final_slot = list_cursor_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_value_reg   <= ESCAPE_VALUE_RST;
            patch_limit_reg    <= PATCH_LIMIT_RST;
            patch_start_reg    <= PATCH_START_RST;
            block_position_reg <= 8'd0;
            list_cursor_reg    <= 8'd0;
            list_full_reg      <= 1'b0;
            in_stream_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_ESCAPE_VALUE: escape_value_reg <= cfg_data;
                    REG_PATCH_LIMIT:  patch_limit_reg  <= cfg_data;
                    REG_PATCH_START:  patch_start_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (push) begin
                block_position_reg <= block_position_next;
                list_cursor_reg    <= list_cursor_next;
                list_full_reg      <= list_full_next;
                in_stream_reg      <= in_stream_next;
            end
        end
    end

endmodule

[sv/ebpl_queue.sv]
module ebpl_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ebpl_pkg::job_t        push_job,
    input  logic                  pop,
    output ebpl_pkg::job_t        head,
    output ebpl_pkg::queue_stat_t q_stat
);
    import ebpl_pkg::*;

    job_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + (QUEUE_AW+1)'(1);
        if (pop && !push) count_next = count_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

[sv/ebpl_back.sv]
module ebpl_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ebpl_pkg::job_t        head,
    input  ebpl_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);
    import ebpl_pkg::*;

    job_t              job_reg;
    logic              job_valid_reg;
    logic              take, done;
    logic [PEND_W-1:0] rest;
    logic [7:0]        slot, value;
    logic              kind;

    assign rest = job_reg.pend & (job_reg.pend - PEND_W'(1));
    assign take = job_valid_reg && m_tready;
    assign done = !job_valid_reg || (take && rest == '0);
    assign pop  = done && !q_stat.empty;

    always_comb begin
        kind  = ITEM_PATCH;
        slot  = job_reg.final_slot;
        value = SEP_MARK;
        if (job_reg.pend[PEND_BYTE]) begin
            kind  = ITEM_PAYLOAD;
            slot  = 8'd0;
            value = job_reg.data;
        end else if (job_reg.pend[PEND_ESC]) begin
            slot  = job_reg.esc_slot;
            value = job_reg.esc_val;
        end else if (job_reg.pend[PEND_BLOCK]) begin
            slot  = job_reg.block_slot;
        end
    end

    assign m_tvalid   = job_valid_reg;
    assign m_tdata    = {value, slot};
    assign m_tuser[0] = kind;
    assign m_tlast    = (rest == '0);

    always_ff @(posedge aclk) begin
        if (done || take) job_reg <= done ? head : job_t'{pend: rest, data: job_reg.data,
            esc_slot: job_reg.esc_slot, esc_val: job_reg.esc_val,
            block_slot: job_reg.block_slot, final_slot: job_reg.final_slot};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (done) begin
            job_valid_reg <= !q_stat.empty;
        end
    end

endmodule

[sv/escape_byte_patch_list_encoder_unit.sv]
// Escape-byte patch list encoder.
// Input stream s_*: one payload byte per item, s_tlast marks the final byte
// of a stream. Result stream m_*: the rewritten payload byte first, then any
// patch list writes that byte causes (escape offset, block separator, final
// separator); m_tlast flags the last result of each input item.
// Configuration: cfg_we/cfg_index/cfg_data write escape value (0), patch
// limit (1) and patch start (2); write only while the block is idle.
// The front stage classifies an item and updates the stream state in the
// cycle it is accepted, then hands a job to a four-entry queue; the back
// stage plays each job out as one result per cycle while m_tready is high.
// Throughput: one item per cycle while each item makes one result and
// m_tready is high; an item with patch writes holds the back stage until
// all its results are taken, the queue absorbing the burst. Reset clears
// all stream state and the queue and loads the register reset values. When
// the receiver stalls, the back stage holds its result, the queue fills and
// s_tready drops once all four entries are taken.
module escape_byte_patch_list_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] slot_index, [15:8] byte_value
    output logic [0:0]  m_tuser,   // [0] item_kind
    output logic        m_tlast
);
    import ebpl_pkg::*;

    job_t        push_job, head;
    queue_stat_t q_stat;
    logic        push, pop;

    ebpl_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .q_stat, .push, .job(push_job)
    );

    ebpl_queue u_queue (
        .aclk, .aresetn, .push, .push_job, .pop, .head, .q_stat
    );

    ebpl_back u_back (
        .aclk, .aresetn, .head, .q_stat, .pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

    a_queue_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_payload_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == ITEM_PAYLOAD |-> m_tdata[7:0] == 8'd0)
        else $error("payload item carries a slot index");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule
